>>> rtl/stfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stfs_pkg
// Shared types and constants for the sigma truncation fitness scaler.
// ----------------------------------------------------------------------------
package stfs_pkg;
    localparam int unsigned FIT_W     = 32;
    localparam int unsigned SCALED_W  = 31;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned SQ_W      = 64;
    localparam logic [CFG_W-1:0] SIGMA_RESET = 16'd8192;

    // Divider control between the top level and the shared divide unit.
    typedef struct packed {
        logic        start;
        logic        is_signed;
    } t_div_ctl;
endpackage
`default_nettype wire

>>> rtl/stfs_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stfs_div
// Shared restoring divider, one quotient bit per cycle. Signed mode gives a
// floor quotient of a signed dividend by a positive divisor.
// ----------------------------------------------------------------------------
module stfs_div #(
    parameter int unsigned DEN_W = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire stfs_pkg::t_div_ctl            i_ctl,
    input  wire logic [stfs_pkg::SQ_W-1:0]     i_num,
    input  wire logic [DEN_W-1:0]              i_den,
    output logic                               o_done,
    output logic [stfs_pkg::SQ_W-1:0]          o_quot
);
    localparam int unsigned W  = stfs_pkg::SQ_W;
    localparam int unsigned CW = $clog2(W + 1);

    logic [W-1:0]     r_quot;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_neg;
    logic             r_done;

    logic [DEN_W+1:0] trial;
    logic             nonzero_rem;

    assign trial = {r_rem, r_quot[W-1]} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_neg  <= i_ctl.is_signed & i_num[W-1];
                // floor(-a/d) = -ceil(a/d) = -(floor((a+d-1)/d))
                r_quot <= (i_ctl.is_signed & i_num[W-1])
                          ? (-i_num) + {{(W-DEN_W){1'b0}}, i_den} - 1'b1 : i_num;
                r_rem  <= '0;
                r_den  <= i_den;
                r_cnt  <= CW'(W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (!trial[DEN_W+1]) begin
                    r_rem  <= trial[DEN_W:0];
                    r_quot <= {r_quot[W-2:0], 1'b1};
                end else begin
                    r_rem  <= {r_rem[DEN_W-1:0], r_quot[W-1]};
                    r_quot <= {r_quot[W-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign nonzero_rem = 1'b0;
    assign o_done = r_done & ~nonzero_rem;
    assign o_quot = r_neg ? -r_quot : r_quot;
endmodule
`default_nettype wire

>>> rtl/sigma_truncation_fitness_scaling.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sigma_truncation_fitness_scaling
// Sigma truncation scaling of a loaded population of Q16.16 fitness values.
// ----------------------------------------------------------------------------
// Usage: send fitness beats on the input channel, last_item on the final one.
// Each beat is stored as it is taken, back to back while ready is high (store
// full: the value is dropped). The closing beat starts a pass: mean by the
// shared divider, a read state and an accumulate state per member to sum
// squared deviations, variance division, a 32-step root (the variance division
// and root are skipped for a single member), one multiply state, then one
// result beat per member, in load order with index and last marker.
// Results sit in an output register; a stalled receiver holds the block on
// that beat. Input ready is low during the pass until the last result enters
// that register. The sigma register is written on the config channel while
// loading; reset sets it to 2.0 and empties the population.
// ----------------------------------------------------------------------------
module sigma_truncation_fitness_scaling #(
    parameter int unsigned MAX_POPULATION = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic signed [31:0]   i_fitness_value,
    input  wire logic                 i_last_item,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [15:0]          i_sigma_multiplier,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [30:0]               o_scaled_fitness,
    output logic [5:0]                o_member_index,
    output logic                      o_last_result
);
    localparam int unsigned AW = (MAX_POPULATION > 1) ? $clog2(MAX_POPULATION) : 1;
    localparam int unsigned NW = $clog2(MAX_POPULATION + 1);
    localparam int unsigned W  = stfs_pkg::SQ_W;

    typedef enum logic [3:0] {
        S_LOAD, S_MEAN, S_MEAN_W, S_SQ_RD, S_SQ, S_VAR, S_VAR_W,
        S_ROOT, S_MUL, S_OUT_RD, S_OUT
    } t_state;

    t_state r_state;
    logic signed [31:0] r_store [MAX_POPULATION];
    logic [NW-1:0]   r_count;
    logic signed [37:0] r_sum;
    logic [15:0]     r_sigma;
    logic [AW-1:0]   r_idx;
    logic signed [31:0] r_rd;
    logic signed [33:0] r_mean;
    logic [W-1:0]    r_ss;
    logic [W-1:0]    r_var;
    logic [W-1:0]    r_rem;
    logic [31:0]     r_root;
    logic [5:0]      r_step;
    logic signed [37:0] r_thr;
    logic            r_ovalid;
    logic [30:0]     r_oscaled;
    logic [5:0]      r_oindex;
    logic            r_olast;

    stfs_pkg::t_div_ctl div_ctl;
    logic [W-1:0]    div_num;
    logic            div_done;
    logic [W-1:0]    div_quot;

    stfs_div #(.DEN_W(NW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   ((r_state == S_MEAN) ? r_count : r_count - 1'b1),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign div_ctl.start     = (r_state == S_MEAN) || (r_state == S_VAR);
    assign div_ctl.is_signed = (r_state == S_MEAN);
    assign div_num = (r_state == S_MEAN) ? W'(r_sum) : r_ss;

    // squared deviation
    logic signed [33:0] dev;
    logic [32:0]        adev;
    logic [65:0]        sq;
    logic [64:0]        ss_sum;
    assign dev    = 34'(r_rd) - r_mean;
    assign adev   = dev[33] ? 33'(-dev) : 33'(dev);
    assign sq     = 66'(adev) * 66'(adev);
    assign ss_sum = {1'b0, r_ss} + 65'(sq);

    // one root step over two radicand bits
    logic [33:0] rtrial;
    logic [W-1:0] rem_sh;
    assign rem_sh = {r_rem[W-3:0], r_var[W-1:W-2]};
    assign rtrial = {r_root, 2'b01};

    logic [47:0] cs_prod;
    assign cs_prod = 48'(r_sigma) * 48'(r_root);

    logic signed [38:0] sval;
    assign sval = 39'(r_rd) - 39'(r_thr);

    logic in_fire, out_fire, full;
    assign o_ready     = (r_state == S_LOAD);
    assign o_cfg_ready = (r_state == S_LOAD);
    assign in_fire  = i_valid & o_ready;
    assign out_fire = r_ovalid & i_ready;
    assign full     = (r_count == NW'(MAX_POPULATION));

    always_ff @(posedge i_clk) begin
        if (in_fire && !full) r_store[r_count[AW-1:0]] <= i_fitness_value;
        r_rd <= r_store[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_count  <= '0;
            r_sum    <= '0;
            r_sigma  <= stfs_pkg::SIGMA_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (out_fire && r_state != S_OUT) r_ovalid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) r_sigma <= i_sigma_multiplier;
            case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (!full) begin
                            r_count <= r_count + 1'b1;
                            r_sum   <= r_sum + 38'(i_fitness_value);
                        end
                        if (i_last_item) r_state <= S_MEAN;
                    end
                end
                S_MEAN: r_state <= S_MEAN_W;
                S_MEAN_W: begin
                    if (div_done) begin
                        r_mean  <= 34'(div_quot);
                        r_ss    <= '0;
                        r_idx   <= '0;
                        r_state <= S_SQ_RD;
                    end
                end
                S_SQ_RD: r_state <= S_SQ;
                S_SQ: begin
                    r_ss <= ss_sum[64] ? {W{1'b1}} : ss_sum[W-1:0];
                    if (NW'(r_idx) == r_count - 1'b1) begin
                        r_var   <= '0;
                        r_root  <= '0;
                        r_rem   <= '0;
                        r_step  <= 6'd32;
                        r_state <= (r_count > NW'(1)) ? S_VAR : S_MUL;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_SQ_RD;
                    end
                end
                S_VAR: r_state <= S_VAR_W;
                S_VAR_W: begin
                    if (div_done) begin
                        r_var   <= div_quot;
                        r_state <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    r_var <= {r_var[W-3:0], 2'b00};
                    if (rem_sh >= W'(rtrial)) begin
                        r_rem  <= rem_sh - W'(rtrial);
                        r_root <= {r_root[30:0], 1'b1};
                    end else begin
                        r_rem  <= rem_sh;
                        r_root <= {r_root[30:0], 1'b0};
                    end
                    r_step <= r_step - 1'b1;
                    if (r_step == 6'd1) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_thr   <= 38'(r_mean) - 38'(cs_prod[47:12]);
                    r_idx   <= '0;
                    r_state <= S_OUT_RD;
                end
                S_OUT_RD: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_ovalid || out_fire) begin
                        r_ovalid  <= 1'b1;
                        r_oscaled <= sval[38] ? '0 :
                                     (sval > 39'sh7FFFFFFF) ? 31'h7FFFFFFF : sval[30:0];
                        r_oindex  <= 6'(r_idx);
                        r_olast   <= (NW'(r_idx) == r_count - 1'b1);
                        if (NW'(r_idx) == r_count - 1'b1) begin
                            r_count <= '0;
                            r_sum   <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= S_OUT_RD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_scaled_fitness = r_oscaled;
    assign o_member_index   = r_oindex;
    assign o_last_result    = r_olast;
endmodule
`default_nettype wire

>>> rtl/stfs_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stfs_checker
// Port-level checks on the sigma truncation scaler.
// ----------------------------------------------------------------------------
module stfs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [5:0]  o_member_index,
    input wire logic        o_last_result,
    input wire logic [30:0] o_scaled_fitness
);
    // output beat holds while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_scaled_fitness))
        else $error("result beat changed under stall");
    // no loading while results are out, save with the last result
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready || o_last_result)
        else $error("ready while results pending");
    // indices advance by one within a run
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_result ##1 o_valid |->
        o_member_index == $past(o_member_index) + 6'd1)
        else $error("member index skipped");
endmodule

bind sigma_truncation_fitness_scaling stfs_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_member_index   (o_member_index),
    .o_last_result    (o_last_result),
    .o_scaled_fitness (o_scaled_fitness)
);
`default_nettype wire
